// ===== design/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  // Payload field widths.
  localparam int REQ_W   = 17;
  localparam int START_W = 16;
  localparam int SIZE_W  = 17;
  localparam int ORDER_W = 5;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // Order that the memory_order register takes at reset.
  localparam logic [ORDER_W-1:0] MEM_ORDER_RST = 5'd16;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SIZE   = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_TAKE   = 6'b001000,
    ST_SPLIT  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

endpackage

// ===== design/buddy_block_allocator.sv =====
// Buddy block allocator: a level-walking sequencer over a per-order free store.
//
//  Channel   Direction  Signals                         Contents
//  -------   ---------  ------------------------------  ---------------------------------
//  request   in         s_tvalid s_tready s_tdata       request_size
//  result    out        m_tvalid m_tready m_tdata       granted, start, end, size
//  config    in         cfg_wr_en cfg_wr_data           memory_order
//
//  After a request beat is accepted, the sequencer steps one order counter through the
//  levels: up to the rounded-up order of the size, then up to the first level with a
//  free block, which it takes, and then back down to the wanted order while writing the
//  freed upper halves into the start store, before it loads the result.
//  A request that fails its size check goes straight from idle to the result state.
//  Reset is synchronous and brings up one free block of the top order at address 0.
//  The request side is ready only while the sequencer is idle; a result waits in the
//  output register while the next request is accepted and walked.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_ORDER = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [16:0] request_size
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] granted, [16:1] block_start,
                                            // [32:17] block_end, [49:33] block_size
  input  logic                   cfg_wr_en,
  input  logic [ORDER_W-1:0]     cfg_wr_data  // memory_order
);

  // Index width for the order levels, and a counter width that can also hold one
  // step past the highest level so that a failed search can be seen.
  localparam int DEPTH = MAX_ORDER + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int LW    = $clog2(MAX_ORDER + 2);

  // Saturate a memory_order value to the highest level this instance holds.
  function automatic logic [LW-1:0] top_of(input logic [ORDER_W-1:0] ord);
    logic [LW-1:0] t;
    if (6'(ord) > 6'(MAX_ORDER)) begin
      t = LW'(MAX_ORDER);
    end else begin
      t = LW'(ord);
    end
    return t;
  endfunction

  // True when 2^l is smaller than the request.
  function automatic logic pow_lt(input logic [LW-1:0] l, input logic [REQ_W-1:0] r);
    logic [5:0] l6;
    logic       lt;
    l6 = 6'(l);
    if (l6 >= 6'd17) begin
      lt = 1'b0;
    end else begin
      lt = ((18'(1) << l6) < {1'b0, r});
    end
    return lt;
  endfunction

  state_t              state;
  logic [ORDER_W-1:0]  mem_order;
  logic [DEPTH-1:0]    level_valid;
  logic [START_W-1:0]  level_start [DEPTH];
  logic [START_W-1:0]  rd_data;

  logic [REQ_W-1:0]    req;
  logic [LW-1:0]       lvl;
  logic [LW-1:0]       want;
  logic [START_W-1:0]  blk_start;
  logic                grant;

  logic [LW-1:0]       top;
  logic [LW-1:0]       lvl_m1;
  logic [START_W-1:0]  half_off;
  logic                in_accept;
  logic                bad_size;
  logic                lvl_free;
  logic                out_free;
  logic                split_we;
  logic                mem_we;
  logic [LW-1:0]       mem_waddr;
  logic [START_W-1:0]  mem_wdata;
  logic                rd_en;
  logic [5:0]          top6;
  logic [REQ_W-1:0]    in_req;
  logic [SIZE_W-1:0]   res_size;

  assign top       = top_of(mem_order);
  assign top6      = 6'(top);
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_req    = s_tdata[REQ_W-1:0];
  assign out_free  = !m_tvalid || m_tready;

  // A zero size, or one larger than the whole memory, fails without a walk.
  assign bad_size = (in_req == '0) ||
                    ((top6 < 6'd17) && ({1'b0, in_req} > (18'(1) << top6)));

  // The level under the counter holds a free block (only read while in range).
  assign lvl_free = (lvl <= top) && level_valid[lvl[IW-1:0]];

  // Splitting one level down frees the upper half at that level.
  assign lvl_m1   = lvl - LW'(1);
  assign half_off = (6'(lvl_m1) < 6'(START_W)) ? (START_W'(1) << lvl_m1) : '0;
  assign split_we = (state == ST_SPLIT) && (lvl > want);

  // One write port on the start store: reset and configuration place the top block at
  // address zero, the split walk writes each freed upper half.
  always_comb begin
    mem_we    = rst || cfg_wr_en || split_we;
    mem_waddr = lvl_m1;
    mem_wdata = blk_start + half_off;
    if (rst) begin
      mem_waddr = top_of(MEM_ORDER_RST);
      mem_wdata = '0;
    end else if (cfg_wr_en) begin
      mem_waddr = top_of(cfg_wr_data);
      mem_wdata = '0;
    end
  end

  assign rd_en = (state == ST_SEARCH) && lvl_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      level_start[mem_waddr[IW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= level_start[lvl[IW-1:0]];
    end
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mem_order   <= MEM_ORDER_RST;
      level_valid <= DEPTH'(1) << top_of(MEM_ORDER_RST);
      m_tvalid    <= 1'b0;
    end else begin
      // In the result state the valid flag is reloaded below, so it is cleared here
      // only in the other states.
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        mem_order   <= cfg_wr_data;
        level_valid <= DEPTH'(1) << top_of(cfg_wr_data);
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= bad_size ? ST_RESULT : ST_SIZE;
          end
        end
        // Step up to the smallest order that holds the request.
        ST_SIZE: begin
          if (!((lvl < top) && pow_lt(lvl, req))) begin
            state <= ST_SEARCH;
          end
        end
        // Step up to the first level that has a free block.
        ST_SEARCH: begin
          if (lvl > top) begin
            state <= ST_RESULT;
          end else if (lvl_free) begin
            state <= ST_TAKE;
          end
        end
        ST_TAKE: begin
          level_valid[lvl[IW-1:0]] <= 1'b0;
          state                    <= ST_SPLIT;
        end
        // Walk back down, leaving the upper half free at each level.
        ST_SPLIT: begin
          if (split_we) begin
            level_valid[lvl_m1[IW-1:0]] <= 1'b1;
          end else begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_size = SIZE_W'(1) << want;

  // Working registers of the walk and the output payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          req   <= in_req;
          lvl   <= '0;
          grant <= 1'b0;
        end
      end
      ST_SIZE: begin
        if ((lvl < top) && pow_lt(lvl, req)) begin
          lvl <= lvl + LW'(1);
        end else begin
          want <= lvl;
        end
      end
      ST_SEARCH: begin
        if ((lvl <= top) && !lvl_free) begin
          lvl <= lvl + LW'(1);
        end
      end
      ST_TAKE: begin
        blk_start <= rd_data;
      end
      ST_SPLIT: begin
        if (split_we) begin
          lvl <= lvl_m1;
        end else begin
          grant <= 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          if (grant) begin
            m_tdata <= OUT_TDATA_W'({res_size,
                                     blk_start + START_W'(res_size - SIZE_W'(1)),
                                     blk_start, 1'b1});
          end else begin
            m_tdata <= '0;
          end
        end
      end
      default: begin
        lvl <= lvl;
      end
    endcase
  end

endmodule

// ===== design/bba_checker.sv =====
// Port-level checks for the buddy block allocator, bound to its top level.
module bba_checker
  import bba_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic               granted;
  logic [START_W-1:0] blk_start;
  logic [START_W-1:0] blk_end;
  logic [SIZE_W-1:0]  blk_size;

  assign granted   = m_tdata[0];
  assign blk_start = m_tdata[16:1];
  assign blk_end   = m_tdata[32:17];
  assign blk_size  = m_tdata[49:33];

  // A failed beat carries all-zero address and size fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !granted) |-> (blk_start == '0 && blk_end == '0 && blk_size == '0))
    else $error("failed allocation with nonzero fields");

  // A granted block is a power of two, aligned to its size, and ends where it should.
  a_grant_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && granted) |-> ($onehot(blk_size) &&
      ((blk_start & START_W'(blk_size - SIZE_W'(1))) == '0) &&
      (blk_end == blk_start + START_W'(blk_size - SIZE_W'(1)))))
    else $error("granted block has a bad size, alignment or end");

  // An accepted beat moves the sequencer out of idle, so the input is not ready right after a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request side ready in the cycle after an accepted beat");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed or dropped");

  // A request beat that waits for the block keeps its size.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
    else $error("waiting request beat changed or dropped");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
